FILE: hw/rtl/lcg_rrd_pkg.sv
// Package for the LCG range draw block: payload types and fixed constants.
`timescale 1ns / 1ps

package lcg_rrd_pkg;

    localparam int SEED_W = 31;
    localparam int DATA_W = 32;
    localparam int PCT_W  = 7;

    localparam logic [SEED_W-1:0] LCG_MUL    = 31'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD    = 31'd12345;
    localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;
    localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;

    localparam logic OP_RANGE = 1'b0;
    localparam logic OP_PROB  = 1'b1;

    localparam logic REG_SEED_START = 1'b0;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] range_min;
        logic [DATA_W-1:0] range_max;
        logic [PCT_W-1:0]  percent;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              hit;
        logic              empty_range;
    } out_t;

endpackage

FILE: hw/rtl/lcg_random_range_draw.sv
// Top level of the LCG range draw block: seed update, shared restoring divider, APB seed register.
`timescale 1ns / 1ps

// Steps from input transfer to result valid: 1 seed update, 31 divider steps, 1 result
// load; an empty range draw goes from the seed update straight to the result load.
// The 31-step restoring divider bounds throughput: a new item is taken only while idle, after
// the previous result is loaded. A finished result waits in the output register while the next
// item is taken; a result not yet taken holds the block in its done state.
// Reset (aresetn low, synchronous): seed and seed_start return to 1, channels go idle.
module lcg_random_range_draw (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lcg_rrd_pkg::in_t     s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lcg_rrd_pkg::out_t    m_payload,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam int CNT_W = $clog2(lcg_rrd_pkg::SEED_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lcg_rrd_pkg::SEED_W - 1);

    state_t                              state_reg, state_next;
    logic [lcg_rrd_pkg::SEED_W-1:0]      seed_reg, seed_next;
    logic [lcg_rrd_pkg::SEED_W-1:0]      seed_start_reg, seed_start_next;
    logic [lcg_rrd_pkg::DATA_W-1:0]      div_d_reg, div_d_next;
    logic [lcg_rrd_pkg::DATA_W-1:0]      rem_reg, rem_next;
    logic [lcg_rrd_pkg::SEED_W-1:0]      dvd_reg, dvd_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                op_reg, op_next;
    logic [lcg_rrd_pkg::DATA_W-1:0]      min_reg, min_next;
    logic [lcg_rrd_pkg::PCT_W-1:0]       pct_reg, pct_next;
    logic                                empty_reg, empty_next;
    logic                                m_valid_reg, m_valid_next;
    lcg_rrd_pkg::out_t                   m_payload_reg, m_payload_next;

    logic                                cfg_wr;
    logic [lcg_rrd_pkg::DATA_W-1:0]      span;
    logic [lcg_rrd_pkg::SEED_W-1:0]      prod;
    logic [lcg_rrd_pkg::SEED_W-1:0]      lcg_seed;
    logic [lcg_rrd_pkg::DATA_W:0]        trial;
    logic [lcg_rrd_pkg::DATA_W:0]        trial_sub;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lcg_rrd_pkg::REG_SEED_START);
    assign prdata = (paddr[2] == lcg_rrd_pkg::REG_SEED_START) ? {1'b0, seed_start_reg} : 32'd0;

    assign span      = s_payload.range_max - s_payload.range_min;
    assign prod      = seed_reg * lcg_rrd_pkg::LCG_MUL;
    assign lcg_seed  = prod + lcg_rrd_pkg::LCG_ADD;
    assign trial     = {rem_reg, dvd_reg[lcg_rrd_pkg::SEED_W-1]};
    assign trial_sub = trial - {1'b0, div_d_reg};

    always_comb begin
        state_next      = state_reg;
        seed_next       = seed_reg;
        seed_start_next = seed_start_reg;
        div_d_next      = div_d_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        min_next        = min_reg;
        pct_next        = pct_reg;
        empty_next      = empty_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_payload_next  = m_payload_reg;

        if (cfg_wr) begin
            seed_start_next = pwdata[lcg_rrd_pkg::SEED_W-1:0];
            seed_next       = pwdata[lcg_rrd_pkg::SEED_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = s_payload.op;
                    min_next = s_payload.range_min;
                    pct_next = (s_payload.percent > lcg_rrd_pkg::PCT_MAX) ?
                               lcg_rrd_pkg::PCT_MAX : s_payload.percent;
                    if (s_payload.op == lcg_rrd_pkg::OP_PROB) begin
                        div_d_next = lcg_rrd_pkg::DATA_W'(lcg_rrd_pkg::PCT_MAX);
                        empty_next = 1'b0;
                    end else begin
                        div_d_next = span;
                        empty_next = (span == '0);
                    end
                    state_next = ST_SEED;
                end
            end
            ST_SEED: begin
                seed_next  = lcg_seed;
                dvd_next   = lcg_seed;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = empty_reg ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (!trial_sub[lcg_rrd_pkg::DATA_W]) begin
                    rem_next = trial_sub[lcg_rrd_pkg::DATA_W-1:0];
                end else begin
                    rem_next = trial[lcg_rrd_pkg::DATA_W-1:0];
                end
                dvd_next = {dvd_reg[lcg_rrd_pkg::SEED_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_payload_next.empty_range = empty_reg;
                    if (op_reg == lcg_rrd_pkg::OP_PROB) begin
                        m_payload_next.value = '0;
                        m_payload_next.hit   = (rem_reg[lcg_rrd_pkg::PCT_W-1:0] < pct_reg);
                    end else begin
                        m_payload_next.hit   = 1'b0;
                        m_payload_next.value = empty_reg ? min_reg : rem_reg + min_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seed_reg       <= lcg_rrd_pkg::SEED_RESET;
            seed_start_reg <= lcg_rrd_pkg::SEED_RESET;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
            empty_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            seed_reg       <= seed_next;
            seed_start_reg <= seed_start_next;
            m_valid_reg    <= m_valid_next;
            cnt_reg        <= cnt_next;
            empty_reg      <= empty_next;
        end
        div_d_reg     <= div_d_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        op_reg        <= op_next;
        min_reg       <= min_next;
        pct_reg       <= pct_next;
        m_payload_reg <= m_payload_next;
    end

    // remainder ends below the divisor
    a_rem_lt_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !empty_reg) |-> (rem_reg < div_d_reg))
        else $error("divider remainder not below divisor");

    a_accept_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SEED))
        else $error("transfer not followed by seed update");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_LAST))
        else $error("divider step count out of range");

    a_hit_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.hit) |-> (m_payload.value == '0 && !m_payload.empty_range))
        else $error("hit with draw fields set");

endmodule
